// ----- src/nfc_type_a_tag_population_responder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Type A tag population responder
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef NFC_TYPE_A_TAG_POPULATION_RESPONDER_ASSERT_SVH
`define NFC_TYPE_A_TAG_POPULATION_RESPONDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define NFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("responder check failed");

// next-cycle implication, sampled on clk, off during rst
`define NFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("responder check failed");

`endif

// ----- src/nfcta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcta_pkg
// Types, constants and helpers shared by the tag population responder.
// ----------------------------------------------------------------------------
package nfcta_pkg;

  localparam int MAX_TAGS    = 8;
  localparam int IDX_W       = $clog2(MAX_TAGS);
  localparam int CNT_W       = $clog2(MAX_TAGS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // host command codes
  localparam logic [2:0] CMD_WAKE    = 3'd0;
  localparam logic [2:0] CMD_ANTICOL = 3'd1;
  localparam logic [2:0] CMD_CRC     = 3'd2;
  localparam logic [2:0] CMD_DEFAULT = 3'd3;
  localparam logic [2:0] CMD_ADD     = 3'd4;
  localparam logic [2:0] CMD_REMOVE  = 3'd5;

  // frame codes
  localparam logic [7:0] SEL_CL1    = 8'h93;
  localparam logic [7:0] SEL_CL2    = 8'h95;
  localparam logic [7:0] SEL_CL3    = 8'h97;
  localparam logic [7:0] SEL_MARK   = 8'h70;
  localparam logic [7:0] FR_HALT    = 8'h50;
  localparam logic [7:0] FR_AUTH_A  = 8'h60;
  localparam logic [7:0] FR_AUTH_B  = 8'h61;
  localparam logic [7:0] FR_READ    = 8'h30;
  localparam logic [7:0] ATQA_LOW   = 8'h44;
  localparam logic [7:0] CASCADE_TAG = 8'h88;
  localparam logic [7:0] SAK_MORE   = 8'h04;
  localparam logic [7:0] SAK_DONE   = 8'h08;
  localparam logic [7:0] READ_FIRST = 8'hFE;

  localparam logic [4:0] IRQ_RX  = 5'h10;
  localparam logic [4:0] IRQ_TX  = 5'h08;
  localparam logic [4:0] IRQ_COL = 5'h04;

  typedef enum logic [3:0] {
    OP_WAKE, OP_DEFAULT, OP_ANTI, OP_SELECT, OP_HALT, OP_READ,
    OP_TXONLY, OP_ADD, OP_REMOVE, OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  lvl;
    logic [31:0] word;
    logic [31:0] mask;
    logic        match_ok;
    logic [55:0] uid;
    logic        is_long;
  } cmd_t;

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_CTZ, B_EMIT} bstate_t;

  // {present, word} of one cascade level of a tag
  function automatic logic [32:0] level_word(input logic [55:0] u, input logic l,
                                             input logic [1:0] lvl);
    logic [32:0] r;
    r = '0;
    if (lvl == 2'd0) begin
      r = l ? {1'b1, u[23:0], CASCADE_TAG} : {1'b1, u[31:0]};
    end else if (lvl == 2'd1 && l) begin
      r = {1'b1, u[55:24]};
    end
    return r;
  endfunction

endpackage

// ----- src/nfc_type_a_tag_population_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_type_a_tag_population_responder
// Emulated population of Type A tags answering reader commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy only rises when
// the two-entry command queue is full. Each command then produces one or more
// result transactions, one per cycle in a contiguous burst marked by
// result_valid, with last_byte on the final one; the receiver cannot stall
// them. The executor handles one command at a time: it loads the command,
// scans table entries (up to the tag count) and finishes the scan, walks to
// a collision bit where needed, then emits the results (1 to 16). The
// longest command is an anticollision frame that scans the full table and
// collides on bit 31.
module nfc_type_a_tag_population_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  frame_length,
  input  logic [7:0]  frame_first,
  input  logic [7:0]  frame_second,
  input  logic [39:0] frame_tail,
  input  logic [55:0] uid_value,
  input  logic        uid_is_long,
  output logic        result_valid,
  output logic [7:0]  response_byte,
  output logic        byte_valid,
  output logic        last_byte,
  output logic [4:0]  irq_flags,
  output logic        timer_expired,
  output logic [7:0]  coll_status,
  output logic        table_full
);
  import nfcta_pkg::*;

  `include "nfc_type_a_tag_population_responder_assert.svh"

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_head;

  assign busy = q_full;

  nfcta_front u_front (
    .start        (start),
    .q_full       (q_full),
    .command      (command),
    .frame_length (frame_length),
    .frame_first  (frame_first),
    .frame_second (frame_second),
    .frame_tail   (frame_tail),
    .uid_value    (uid_value),
    .uid_is_long  (uid_is_long),
    .push         (q_push),
    .push_data    (q_in)
  );

  nfcta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  nfcta_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .response_byte (response_byte),
    .byte_valid    (byte_valid),
    .last_byte     (last_byte),
    .irq_flags     (irq_flags),
    .timer_expired (timer_expired),
    .coll_status   (coll_status),
    .table_full    (table_full)
  );

  `NFC_ASSERT_NXT(a_burst_contiguous, result_valid && !last_byte, result_valid)
  `NFC_ASSERT_IMP(a_full_has_no_data, result_valid && table_full, !byte_valid)
  `NFC_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)

endmodule

// ----- src/nfcta_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcta_front
// Accepts host commands and decodes them into queue transactions.
// ----------------------------------------------------------------------------
module nfcta_front (
  input  logic               start,
  input  logic               q_full,
  input  logic [2:0]         command,
  input  logic [2:0]         frame_length,
  input  logic [7:0]         frame_first,
  input  logic [7:0]         frame_second,
  input  logic [39:0]        frame_tail,
  input  logic [55:0]        uid_value,
  input  logic               uid_is_long,
  output logic               push,
  output nfcta_pkg::cmd_t    push_data
);
  import nfcta_pkg::*;

  logic [55:0] raw;
  logic [7:0]  fr [7];
  logic [3:0]  hi, lo, full_b;
  logic [6:0]  nb;
  logic [31:0] pre, pmask;
  logic [1:0]  lvl;

  assign push = start && !q_full;
  assign raw  = {frame_tail, frame_second, frame_first};

  always_comb begin
    for (int j = 0; j < 7; j++) begin
      fr[j] = (3'(j) < frame_length) ? raw[j*8 +: 8] : 8'h00;
    end
    hi     = fr[1][7:4];
    lo     = fr[1][3:0];
    full_b = (hi >= 4'd2) ? hi - 4'd2 : 4'd0;
    nb     = {full_b, 3'b000} + {3'b000, lo};
    pmask  = (nb >= 7'd32) ? '1 : ((32'h1 << nb[4:0]) - 32'h1);
    pre    = {fr[5], fr[4], fr[3], fr[2]};
    lvl    = (fr[0] == SEL_CL1) ? 2'd0 : (fr[0] == SEL_CL2) ? 2'd1 : 2'd2;

    push_data          = '0;
    push_data.op       = OP_NOP;
    push_data.lvl      = lvl;
    push_data.word     = pre;
    push_data.mask     = '1;
    push_data.match_ok = 1'b1;
    push_data.is_long  = uid_is_long;
    push_data.uid      = uid_is_long ? uid_value : {24'h0, uid_value[31:0]};

    unique case (command)
      CMD_WAKE:    push_data.op = OP_WAKE;
      CMD_DEFAULT: push_data.op = OP_DEFAULT;
      CMD_ADD:     push_data.op = OP_ADD;
      CMD_REMOVE:  push_data.op = OP_REMOVE;
      CMD_ANTICOL: begin
        push_data.op       = OP_ANTI;
        push_data.mask     = pmask;
        push_data.match_ok = (frame_length >= 3'd2) && (lo <= 4'd7) && (nb <= 7'd32);
      end
      CMD_CRC: begin
        priority if (frame_length == 3'd0) begin
          push_data.op = OP_TXONLY;
        end else if ((fr[0] == SEL_CL1 || fr[0] == SEL_CL2 || fr[0] == SEL_CL3)
                     && frame_length >= 3'd2 && fr[1] == SEL_MARK) begin
          push_data.op = (frame_length >= 3'd6) ? OP_SELECT : OP_TXONLY;
        end else if (fr[0] == FR_HALT) begin
          push_data.op = OP_HALT;
        end else if (fr[0] == FR_READ) begin
          push_data.op = OP_READ;
        end else begin
          // auth and anything unknown: transmit end only
          push_data.op = OP_TXONLY;
        end
      end
      default: push_data.op = OP_NOP;
    endcase
  end

endmodule

// ----- src/nfcta_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcta_queue
// Short command queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module nfcta_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nfcta_pkg::cmd_t  push_data,
  input  logic             pop,
  output nfcta_pkg::cmd_t  head,
  output logic             full,
  output logic             empty
);
  import nfcta_pkg::*;

  cmd_t            entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] count;

  assign full  = (count == QC_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QC_W'(push) - QC_W'(pop);
    end
  end

endmodule

// ----- src/nfcta_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcta_back
// Executes queued commands: scans the tag table, then streams the response.
// ----------------------------------------------------------------------------
module nfcta_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  nfcta_pkg::cmd_t  q_head,
  output logic             pop,
  output logic             result_valid,
  output logic [7:0]       response_byte,
  output logic             byte_valid,
  output logic             last_byte,
  output logic [4:0]       irq_flags,
  output logic             timer_expired,
  output logic [7:0]       coll_status,
  output logic             table_full
);
  import nfcta_pkg::*;

  bstate_t state, state_next;
  cmd_t    work;

  logic [55:0]         tag_uid  [MAX_TAGS];
  logic                tag_long [MAX_TAGS];
  logic [MAX_TAGS-1:0] halted;
  logic [CNT_W-1:0]    tag_count, scan, keep;

  logic [31:0] sel_uid, wa, wb, diff;
  logic [1:0]  sel_level, hits;
  logic        sel_valid, found, stop;
  logic [7:0]  col_pos;
  logic [4:0]  bit_pos;
  logic [39:0] rbuf;
  logic        is_read;
  logic [4:0]  nbytes, emit;
  logic [4:0]  irq_r;
  logic        timer_r, full_r;

  logic [IDX_W-1:0] idx;
  logic [55:0] cur_uid;
  logic        cur_long, cur_halted;
  logic [1:0]  lw_lvl;
  logic [32:0] lw_r;
  logic        hit, same, halt_hit, scans, scan_end, ctz_done, emit_last;
  logic [31:0] wm;
  logic [7:0]  bcc, out_byte;
  logic        wr_en, wr_long;
  logic [IDX_W-1:0] wr_idx;
  logic [55:0] wr_uid;

  assign idx        = scan[IDX_W-1:0];
  assign cur_uid    = tag_uid[idx];
  assign cur_long   = tag_long[idx];
  assign cur_halted = halted[idx];
  assign lw_lvl     = (work.op == OP_HALT) ? sel_level : work.lvl;
  assign lw_r       = level_word(cur_uid, cur_long, lw_lvl);
  assign hit        = !cur_halted && lw_r[32] && work.match_ok &&
                      (((lw_r[31:0] ^ work.word) & work.mask) == 32'h0);
  assign same       = (cur_uid == work.uid) && (cur_long == work.is_long);
  assign halt_hit   = !cur_halted && (!sel_valid || (lw_r[32] && lw_r[31:0] == sel_uid));
  assign scans      = (work.op == OP_ANTI) || (work.op == OP_SELECT) ||
                      (work.op == OP_HALT) || (work.op == OP_ADD) || (work.op == OP_REMOVE);
  assign scan_end   = !scans || stop || (scan == tag_count);
  assign ctz_done   = diff[0] || (diff == 32'h0);
  assign emit_last  = (nbytes == 5'd0) || (emit == nbytes - 5'd1);
  assign pop        = (state == B_IDLE) && !q_empty;

  assign wm  = wa & ~work.mask;
  assign bcc = wm[7:0] ^ wm[15:8] ^ wm[23:16] ^ wm[31:24];

  always_comb begin
    unique case (emit[2:0])
      3'd0:    out_byte = rbuf[7:0];
      3'd1:    out_byte = rbuf[15:8];
      3'd2:    out_byte = rbuf[23:16];
      3'd3:    out_byte = rbuf[31:24];
      3'd4:    out_byte = rbuf[39:32];
      default: out_byte = 8'h00;
    endcase
    if (is_read) begin
      out_byte = (emit == 5'd0) ? READ_FIRST : 8'h00;
    end
  end

  // table write port: compaction on remove, append on add
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = keep[IDX_W-1:0];
    wr_uid  = cur_uid;
    wr_long = cur_long;
    if (state == B_SCAN) begin
      if (!scan_end && work.op == OP_REMOVE && !same) begin
        wr_en = 1'b1;
      end else if (scan_end && work.op == OP_ADD && !found &&
                   tag_count < CNT_W'(MAX_TAGS)) begin
        wr_en   = 1'b1;
        wr_idx  = tag_count[IDX_W-1:0];
        wr_uid  = work.uid;
        wr_long = work.is_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_uid[wr_idx]  <= wr_uid;
      tag_long[wr_idx] <= wr_long;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_SCAN;
      B_SCAN: begin
        if (scan_end) begin
          state_next = (work.op == OP_ANTI && hits == 2'd2) ? B_CTZ : B_EMIT;
        end
      end
      B_CTZ:  if (ctz_done) state_next = B_EMIT;
      B_EMIT: if (emit_last) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_count    <= '0;
      halted       <= '0;
      sel_valid    <= 1'b0;
      sel_level    <= 2'd0;
      sel_uid      <= 32'h0;
      col_pos      <= 8'h00;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            work    <= q_head;
            scan    <= '0;
            keep    <= '0;
            hits    <= 2'd0;
            found   <= 1'b0;
            stop    <= 1'b0;
            emit    <= 5'd0;
            is_read <= 1'b0;
            nbytes  <= 5'd0;
            irq_r   <= 5'h00;
            timer_r <= 1'b0;
            full_r  <= 1'b0;
          end
        end
        B_SCAN: begin
          if (!scan_end) begin
            scan <= scan + 1'b1;
            unique case (work.op)
              OP_ANTI: begin
                if (hit) begin
                  if (hits == 2'd0) wa <= lw_r[31:0];
                  else wb <= lw_r[31:0];
                  hits <= hits + 2'd1;
                  if (hits == 2'd1) stop <= 1'b1;
                end
              end
              OP_SELECT: begin
                if (hit) begin
                  found     <= 1'b1;
                  stop      <= 1'b1;
                  rbuf      <= {32'h0, (work.lvl == 2'd0 && cur_long) ? SAK_MORE : SAK_DONE};
                  sel_uid   <= lw_r[31:0];
                  sel_level <= work.lvl;
                  sel_valid <= 1'b1;
                end
              end
              OP_HALT: begin
                if (halt_hit) begin
                  halted[idx] <= 1'b1;
                  stop        <= 1'b1;
                end
              end
              OP_ADD: begin
                if (same) begin
                  halted[idx] <= 1'b0;
                  found       <= 1'b1;
                  stop        <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (!same) begin
                  halted[keep[IDX_W-1:0]] <= cur_halted;
                  keep <= keep + 1'b1;
                end
              end
              default: ;
            endcase
          end else begin
            unique case (work.op)
              OP_WAKE: begin
                col_pos   <= 8'h00;
                sel_valid <= 1'b0;
                halted    <= '0;
                if (tag_count != '0) begin
                  rbuf   <= {32'h0, ATQA_LOW};
                  nbytes <= 5'd2;
                  irq_r  <= IRQ_RX;
                end else begin
                  timer_r <= 1'b1;
                end
              end
              OP_DEFAULT: halted <= '0;
              OP_ANTI: begin
                col_pos <= 8'h00;
                if (hits == 2'd0) begin
                  timer_r <= 1'b1;
                end else if (hits == 2'd1) begin
                  rbuf   <= {bcc, wm};
                  nbytes <= 5'd5;
                  irq_r  <= IRQ_RX;
                end else begin
                  irq_r   <= IRQ_COL;
                  diff    <= wa ^ wb;
                  bit_pos <= 5'd0;
                end
              end
              OP_SELECT: begin
                if (found) begin
                  nbytes <= 5'd1;
                  irq_r  <= IRQ_RX | IRQ_TX;
                end else begin
                  irq_r <= IRQ_TX;
                end
              end
              OP_HALT: sel_valid <= 1'b0;
              OP_READ: begin
                is_read <= 1'b1;
                nbytes  <= 5'd16;
                irq_r   <= IRQ_RX | IRQ_TX;
              end
              OP_TXONLY: irq_r <= IRQ_TX;
              OP_ADD: begin
                if (!found) begin
                  if (tag_count < CNT_W'(MAX_TAGS)) begin
                    halted[tag_count[IDX_W-1:0]] <= 1'b0;
                    tag_count <= tag_count + 1'b1;
                  end else begin
                    full_r <= 1'b1;
                  end
                end
              end
              OP_REMOVE: tag_count <= keep;
              default: ;
            endcase
          end
        end
        B_CTZ: begin
          // walk to the lowest differing bit
          if (!ctz_done) begin
            diff    <= diff >> 1;
            bit_pos <= bit_pos + 5'd1;
          end else begin
            col_pos <= 8'd16 + {3'b000, bit_pos};
          end
        end
        B_EMIT: begin
          result_valid  <= 1'b1;
          response_byte <= (nbytes == 5'd0) ? 8'h00 : out_byte;
          byte_valid    <= (nbytes != 5'd0);
          last_byte     <= emit_last;
          irq_flags     <= irq_r;
          timer_expired <= timer_r;
          coll_status   <= {col_pos[6:3], col_pos[2:0], 1'b0};
          table_full    <= full_r;
          emit          <= emit + 5'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_nfc_type_a_tag_population_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag population responder testbench
// Walks a table of directed commands, then a long random mix of add/remove,
// wake/anticol/select/halt/read/auth commands and noise, with bursty issue.
// Every result transaction is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module tb_nfc_type_a_tag_population_responder;
  import nfcta_pkg::*;

  localparam int N_RANDOM  = 444;
  localparam int POOL_SIZE = 12;
  localparam int WD_LIMIT  = 5000;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  len;
    logic [7:0]  f0;
    logic [7:0]  f1;
    logic [39:0] tail;
    logic [55:0] uid;
    logic        lng;
  } cmd_item_t;

  typedef struct {
    cmd_item_t   it;
    bit          chk;
    logic [7:0]  e_byte;
    logic [4:0]  e_irq;
    logic        e_timer;
  } stim_row_t;

  typedef struct {
    logic [7:0] rbyte;
    logic       bv;
    logic       last;
    logic [4:0] irq;
    logic       timer;
    logic [7:0] disp;
    logic       full;
  } resp_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  command = '0;
  logic [2:0]  frame_length = '0;
  logic [7:0]  frame_first = '0;
  logic [7:0]  frame_second = '0;
  logic [39:0] frame_tail = '0;
  logic [55:0] uid_value = '0;
  logic        uid_is_long = 0;
  logic        result_valid;
  logic [7:0]  response_byte;
  logic        byte_valid;
  logic        last_byte;
  logic [4:0]  irq_flags;
  logic        timer_expired;
  logic [7:0]  coll_status;
  logic        table_full;

  nfc_type_a_tag_population_responder i_dut (.*);

  always #5 clk = ~clk;

  // tag table as the predictor sees it
  logic [55:0] tbl_uid [MAX_TAGS];
  logic        tbl_long [MAX_TAGS];
  logic        tbl_halted [MAX_TAGS];
  int          tbl_count = 0;
  logic [31:0] sel_word = '0;
  logic [1:0]  sel_lvl = '0;
  logic        sel_valid = 0;
  int          coll_pos = 0;

  resp_t       response_queue [$];
  stim_row_t   directed [$];
  int          errors = 0;
  int          idle_cycles = 0;

  logic [55:0] pool_uid [POOL_SIZE];
  logic        pool_long [POOL_SIZE];

  function automatic bit cascade_word(input logic [55:0] u, input logic l,
                                      input logic [1:0] lvl, output logic [31:0] w);
    w = '0;
    if (lvl == 2'd0) begin
      w = l ? {u[23:0], CASCADE_TAG} : u[31:0];
      return 1;
    end
    if (lvl == 2'd1 && l) begin
      w = u[55:24];
      return 1;
    end
    return 0;
  endfunction

  task automatic predict_responses(input cmd_item_t it);
    logic [7:0]  fr [7];
    logic [7:0]  data [16];
    logic [55:0] uid;
    logic [31:0] pre, mask, wa, wb, w, d;
    logic [1:0]  lvl;
    int          nbytes, hits, nb, hi, lo, items, k, b;
    logic [4:0]  irq;
    bit          timer, full, found;
    resp_t       r;
    nbytes = 0; irq = '0; timer = 0; full = 0; wa = '0; wb = '0;
    for (int i = 0; i < 16; i++) data[i] = '0;
    fr[0] = it.f0; fr[1] = it.f1;
    for (int i = 0; i < 5; i++) fr[2+i] = it.tail[8*i +: 8];
    for (int i = it.len; i < 7; i++) fr[i] = '0;
    uid = it.lng ? it.uid : {24'd0, it.uid[31:0]};
    case (it.cmd)
      CMD_WAKE: begin
        coll_pos = 0; sel_valid = 0;
        for (int i = 0; i < tbl_count; i++) tbl_halted[i] = 0;
        if (tbl_count > 0) begin
          data[0] = ATQA_LOW; data[1] = 8'h00; nbytes = 2; irq = IRQ_RX;
        end else timer = 1;
      end
      CMD_ANTICOL: begin
        coll_pos = 0;
        if (it.len < 2) timer = 1;
        else begin
          hi = fr[1][7:4]; lo = fr[1][3:0];
          nb = (hi >= 2 ? hi - 2 : 0) * 8 + lo;
          lvl = fr[0] == SEL_CL1 ? 2'd0 : fr[0] == SEL_CL2 ? 2'd1 : 2'd2;
          pre = {fr[5], fr[4], fr[3], fr[2]};
          mask = nb >= 32 ? 32'hFFFF_FFFF : ((32'd1 << nb) - 32'd1);
          hits = 0;
          if (lo <= 7 && nb <= 32) begin
            for (int i = 0; i < tbl_count && hits < 2; i++) begin
              if (tbl_halted[i] || !cascade_word(tbl_uid[i], tbl_long[i], lvl, w)) continue;
              if (((w ^ pre) & mask) != 0) continue;
              if (hits == 0) wa = w; else wb = w;
              hits++;
            end
          end
          if (hits == 0) timer = 1;
          else if (hits == 1) begin
            wa &= ~mask;
            for (int i = 0; i < 4; i++) data[i] = wa[8*i +: 8];
            data[4] = data[0] ^ data[1] ^ data[2] ^ data[3];
            nbytes = 5; irq = IRQ_RX;
          end else begin
            d = wa ^ wb; b = 0;
            if (d != 0) while (d[b] == 1'b0) b++;
            coll_pos = 16 + b;
            irq = IRQ_COL;
          end
        end
      end
      CMD_CRC: begin
        if (it.len == 0) irq = IRQ_TX;
        else if ((fr[0] == SEL_CL1 || fr[0] == SEL_CL2 || fr[0] == SEL_CL3) &&
                 it.len >= 2 && fr[1] == SEL_MARK) begin
          irq = IRQ_TX;
          if (it.len >= 6) begin
            pre = {fr[5], fr[4], fr[3], fr[2]};
            lvl = fr[0] == SEL_CL1 ? 2'd0 : fr[0] == SEL_CL2 ? 2'd1 : 2'd2;
            for (int i = 0; i < tbl_count; i++) begin
              if (tbl_halted[i] || !cascade_word(tbl_uid[i], tbl_long[i], lvl, w) ||
                  w != pre) continue;
              data[0] = (lvl == 2'd0 && tbl_long[i]) ? SAK_MORE : SAK_DONE;
              nbytes = 1; irq = IRQ_RX | IRQ_TX;
              sel_word = w; sel_lvl = lvl; sel_valid = 1;
              break;
            end
          end
        end else if (fr[0] == FR_HALT) begin
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_halted[i]) continue;
            if (sel_valid && (!cascade_word(tbl_uid[i], tbl_long[i], sel_lvl, w) ||
                              w != sel_word)) continue;
            tbl_halted[i] = 1;
            break;
          end
          sel_valid = 0;
        end else if (fr[0] == FR_AUTH_A || fr[0] == FR_AUTH_B) irq = IRQ_TX;
        else if (fr[0] == FR_READ) begin
          data[0] = READ_FIRST; nbytes = 16; irq = IRQ_RX | IRQ_TX;
        end else irq = IRQ_TX;
      end
      CMD_DEFAULT: for (int i = 0; i < tbl_count; i++) tbl_halted[i] = 0;
      CMD_ADD: begin
        found = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_uid[i] == uid && tbl_long[i] == it.lng) begin
            tbl_halted[i] = 0; found = 1; break;
          end
        end
        if (!found) begin
          if (tbl_count < MAX_TAGS) begin
            tbl_uid[tbl_count] = uid; tbl_long[tbl_count] = it.lng;
            tbl_halted[tbl_count] = 0; tbl_count++;
          end else full = 1;
        end
      end
      CMD_REMOVE: begin
        k = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_uid[i] == uid && tbl_long[i] == it.lng) continue;
          tbl_uid[k] = tbl_uid[i]; tbl_long[k] = tbl_long[i];
          tbl_halted[k] = tbl_halted[i]; k++;
        end
        tbl_count = k;
      end
      default: ;
    endcase
    items = nbytes ? nbytes : 1;
    for (int i = 0; i < items; i++) begin
      r.rbyte = nbytes ? data[i] : 8'h00;
      r.bv    = nbytes != 0;
      r.last  = (i + 1 == items);
      r.irq   = irq;
      r.timer = timer;
      r.disp  = {4'(coll_pos >> 3), 3'(coll_pos & 7), 1'b0};
      r.full  = full;
      response_queue.insert(response_queue.size(), r);
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic stim_row_t row(input logic [2:0] cmd, input logic [2:0] len,
                                    input logic [7:0] f0, input logic [7:0] f1,
                                    input logic [39:0] tail, input logic [55:0] uid,
                                    input logic lng, input bit chk,
                                    input logic [7:0] eb, input logic [4:0] ei,
                                    input logic et);
    stim_row_t s;
    s.it = '{cmd, len, f0, f1, tail, uid, lng};
    s.chk = chk; s.e_byte = eb; s.e_irq = ei; s.e_timer = et;
    return s;
  endfunction

  task automatic add_row(input stim_row_t s);
    directed.insert(directed.size(), s);
  endtask

  function automatic logic [55:0] rand56();
    return 56'({$urandom, $urandom});
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t   it;
    int          r, p, nb;
    logic [1:0]  lvl;
    logic [31:0] w, mask;
    it = '{CMD_CRC, 3'd7, 8'h00, 8'h00, 40'({$urandom, $urandom}), rand56(),
           1'($urandom)};
    r = $urandom_range(0, 99);
    p = $urandom_range(0, POOL_SIZE - 1);
    lvl = 2'($urandom_range(0, 1));
    if (!cascade_word(pool_uid[p], pool_long[p], lvl, w)) w = $urandom;
    if (r < 11) begin
      it.cmd = CMD_ADD; it.uid = pool_uid[p]; it.lng = pool_long[p];
    end else if (r < 17) begin
      it.cmd = CMD_REMOVE;
      if ($urandom_range(0, 4) != 0) begin
        it.uid = pool_uid[p]; it.lng = pool_long[p];
      end
    end else if (r < 24) it.cmd = CMD_WAKE;
    else if (r < 27) it.cmd = CMD_DEFAULT;
    else if (r < 50) begin
      it.cmd = CMD_ANTICOL;
      nb = $urandom_range(0, 32);
      mask = nb >= 32 ? 32'hFFFF_FFFF : ((32'd1 << nb) - 32'd1);
      it.f0 = $urandom_range(0, 9) == 0 ? 8'($urandom) : (lvl ? SEL_CL2 : SEL_CL1);
      it.f1 = {4'(nb / 8 + 2), 4'(nb % 8)};
      it.tail[31:0] = (w & mask) | ($urandom & ~mask);
      it.len = $urandom_range(0, 5) == 0 ? 3'($urandom_range(2, 7)) : 3'd7;
    end else if (r < 66) begin
      it.f0 = lvl ? SEL_CL2 : ($urandom_range(0, 7) == 0 ? SEL_CL3 : SEL_CL1);
      it.f1 = SEL_MARK;
      if ($urandom_range(0, 5) != 0) it.tail[31:0] = w;
      it.len = $urandom_range(0, 5) == 0 ? 3'($urandom_range(1, 7)) : 3'd7;
    end else if (r < 73) begin
      it.f0 = FR_HALT; it.len = 3'($urandom_range(1, 7));
    end else if (r < 79) begin
      it.f0 = FR_READ; it.len = 3'($urandom_range(1, 7));
    end else if (r < 83) begin
      it.f0 = $urandom_range(0, 1) ? FR_AUTH_A : FR_AUTH_B;
    end else begin
      it.cmd = 3'($urandom); it.len = 3'($urandom);
      it.f0 = 8'($urandom); it.f1 = 8'($urandom);
    end
    return it;
  endfunction

  // check results; watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    resp_t e;
    if (!rst) begin
      if ((start && !busy) || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (result_valid) begin
        if (response_queue.size() == 0) report("unexpected result", response_byte, 0);
        else begin
          e = response_queue.pop_front();
          if (response_byte !== e.rbyte) report("response_byte", response_byte, e.rbyte);
          if (byte_valid !== e.bv) report("byte_valid", byte_valid, e.bv);
          if (last_byte !== e.last) report("last_byte", last_byte, e.last);
          if (irq_flags !== e.irq) report("irq_flags", irq_flags, e.irq);
          if (timer_expired !== e.timer) report("timer_expired", timer_expired, e.timer);
          if (coll_status !== e.disp)
            report("coll_status", coll_status, e.disp);
          if (table_full !== e.full) report("table_full", table_full, e.full);
        end
      end
    end
  end

  initial begin
    stim_row_t s;
    int        burst_left, base, total, gap;
    for (int j = 0; j < POOL_SIZE; j++) begin
      pool_uid[j] = rand56(); pool_long[j] = 1'($urandom);
      // pairs of long tags share their level-one word
      if (j % 4 == 1) begin
        pool_long[j-1] = 1; pool_long[j] = 1;
        pool_uid[j][23:0] = pool_uid[j-1][23:0];
      end
    end
    add_row(row(CMD_WAKE, 7, 0, 0, 0, 0, 0, 1, 8'h00, 5'h00, 1));
    add_row(row(CMD_ANTICOL, 1, SEL_CL1, 0, 0, 0, 0, 1, 8'h00, 5'h00, 1));
    add_row(row(CMD_CRC, 0, FR_READ, 0, 0, 0, 0, 1, 8'h00, IRQ_TX, 0));
    add_row(row(3'd6, 7, 8'hFF, 8'hFF, '1, '1, 1, 1, 8'h00, 5'h00, 0));
    add_row(row(3'd7, 0, 0, 0, 0, 0, 0, 1, 8'h00, 5'h00, 0));
    add_row(row(CMD_ADD, 0, 0, 0, 0, 56'hAB_CDEF_1122_3344, 0, 0, 0, 0, 0));
    add_row(row(CMD_ADD, 0, 0, 0, 0, '1, 1, 0, 0, 0, 0));
    add_row(row(CMD_ADD, 0, 0, 0, 0, 56'h0, 1, 0, 0, 0, 0));
    add_row(row(CMD_ADD, 0, 0, 0, 0, 56'h11_2233_4455_6677, 1, 0, 0, 0, 0));
    add_row(row(CMD_ADD, 0, 0, 0, 0, 56'h00_0000_1122_3344, 0, 0, 0, 0, 0));
    add_row(row(CMD_WAKE, 0, 0, 0, 0, 0, 0, 1, ATQA_LOW, IRQ_RX, 0));
    add_row(row(CMD_ANTICOL, 2, SEL_CL1, 8'h20, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_ANTICOL, 7, SEL_CL1, 8'h28, 0, 0, 0, 1, 8'h00, 5'h00, 1));
    add_row(row(CMD_ANTICOL, 7, SEL_CL1, 8'h70, 0, 0, 0, 1, 8'h00, 5'h00, 1));
    add_row(row(CMD_ANTICOL, 7, 8'h20, 8'h20, 0, 0, 0, 1, 8'h00, 5'h00, 1));
    add_row(row(CMD_ANTICOL, 7, SEL_CL2, 8'h20, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_ANTICOL, 7, SEL_CL2, 8'h38, 40'h44556677, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_CRC, 5, SEL_CL1, SEL_MARK, 40'h11223344, 0, 0,
                1, 8'h00, IRQ_TX, 0));
    add_row(row(CMD_CRC, 7, SEL_CL1, SEL_MARK, 40'h11223344, 0, 0,
                1, SAK_DONE, IRQ_RX | IRQ_TX, 0));
    add_row(row(CMD_CRC, 2, FR_HALT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_CRC, 2, FR_HALT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_CRC, 2, FR_READ, 8'h04, 0, 0, 0, 1, READ_FIRST,
                IRQ_RX | IRQ_TX, 0));
    add_row(row(CMD_CRC, 4, FR_AUTH_A, 0, 0, 0, 0, 1, 8'h00, IRQ_TX, 0));
    add_row(row(CMD_CRC, 7, 8'hFF, 8'hFF, '1, 0, 0, 1, 8'h00, IRQ_TX, 0));
    add_row(row(CMD_DEFAULT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(CMD_REMOVE, 0, 0, 0, 0, 56'h0, 1, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    burst_left = $urandom_range(1, 8);
    total = directed.size() + N_RANDOM;
    for (int n = 0; n < total; n++) begin
      if (n < directed.size()) s = directed[n];
      else begin
        s.it = random_command(); s.chk = 0;
      end
      start <= 1;
      command <= s.it.cmd; frame_length <= s.it.len;
      frame_first <= s.it.f0; frame_second <= s.it.f1;
      frame_tail <= s.it.tail; uid_value <= s.it.uid; uid_is_long <= s.it.lng;
      @(posedge clk);
      while (busy) @(posedge clk);
      base = response_queue.size();
      predict_responses(s.it);
      if (s.chk) begin
        response_queue[base].rbyte = s.e_byte;
        for (int k = base; k < response_queue.size(); k++) begin
          response_queue[k].irq = s.e_irq;
          response_queue[k].timer = s.e_timer;
        end
      end
      burst_left--;
      if (burst_left == 0) begin
        // hold off the next transaction for a random gap
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          start <= 0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
    start <= 0;
    while (response_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/nfcta_pkg.sv
src/nfcta_front.sv
src/nfcta_queue.sv
src/nfcta_back.sv
src/nfc_type_a_tag_population_responder.sv
tb/sv/tb_nfc_type_a_tag_population_responder.sv
